>>> rtl/lfu_pkg.sv
// ---------------------------------------------------------------------------
// lfu_pkg - shared types and constants for the LFU cache
// Entry layout, cell control word, sequencer states and sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int DEPTH   = 16;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 16;
	localparam int CAP_W   = 5;
	localparam int FILL_W  = $clog2(DEPTH + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(DEPTH);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
	} lfu_entry_t;

	typedef enum logic [2:0] {
		CELL_IDLE,
		CELL_LOOK,
		CELL_HIT,
		CELL_SHIFT,
		CELL_PROMO
	} lfu_cell_op_t;

	typedef struct packed {
		lfu_cell_op_t     op;
		logic             put;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} lfu_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_OP,
		ST_PROMO
	} lfu_state_t;

endpackage

`default_nettype wire

>>> rtl/lfu_cell.sv
// ---------------------------------------------------------------------------
// lfu_cell - one rank slot of the LFU cache
// Holds one entry, compares its key, bumps its count, and trades its entry
// with either neighbor during insert shifts and promotion swaps.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfu_pkg::lfu_cell_ctl_t ctl,
	input  wire logic                 sel,
	input  wire logic                 valid,
	input  wire logic                 next_valid,
	input  wire logic                 prev_swap,
	input  wire lfu_pkg::lfu_entry_t  prev_entry,
	input  wire lfu_pkg::lfu_entry_t  next_entry,
	output lfu_pkg::lfu_entry_t       entry,
	output logic                      match,
	output logic                      swap
);
	import lfu_pkg::*;

	lfu_entry_t entry_q;
	logic       match_q;

	assign entry = entry_q;
	assign match = match_q;

	// token holder moves up past a neighbor with equal or lower count
	assign swap = (ctl.op == CELL_PROMO) && sel && next_valid &&
	              (next_entry.count <= entry_q.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.op == CELL_LOOK) begin
			match_q <= valid && (entry_q.key == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_IDLE, CELL_LOOK: begin
			end
			CELL_HIT: begin
				if (sel) begin
					if (entry_q.count != COUNT_MAX) begin
						entry_q.count <= entry_q.count + COUNT_W'(1);
					end
					if (ctl.put) begin
						entry_q.value <= ctl.value;
					end
				end
			end
			CELL_SHIFT: begin
				if (sel) begin
					entry_q <= prev_entry;
				end
			end
			CELL_PROMO: begin
				if (swap) begin
					entry_q <= next_entry;
				end else if (prev_swap) begin
					entry_q <= prev_entry;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/lfu_cache.sv
// ---------------------------------------------------------------------------
// lfu_cache - least-frequently-used key/value cache
// A row of rank cells ordered by use count (ascending, least recently
// promoted first), driven by a small sequencer.
// ---------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ---------------------------------
//  item in   cmd, key, value                start high while busy low
//  result    hit, data                      done high for one cycle
//  config    cfg_wdata (capacity)           cfg_we high, taken at once
//
// An item runs lookup, decide and result on a get miss, and otherwise
// lookup, decide, a climb over the rank positions the entry moves up,
// and result. The climb is one neighbor swap per cycle along the cell row.
// Reset clears the fill count and sets capacity to DEPTH; entries are not
// cleared, since only cells below the fill count are ever looked at.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cache (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        cmd,
	input  wire logic [lfu_pkg::KEY_W-1:0]   key,
	input  wire logic [lfu_pkg::VAL_W-1:0]   value,
	output logic                             done,
	output logic                             hit,
	output logic [lfu_pkg::VAL_W-1:0]        data,
	input  wire logic                        cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0]   cfg_wdata
);
	import lfu_pkg::*;

	lfu_state_t state_q, state_d;

	// item held for the whole operation
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic [CAP_W-1:0]  cap_q;
	logic [FILL_W-1:0] fill_q;
	logic [DEPTH-1:0]  token_q;

	logic             done_q;
	logic             hit_q;
	logic [VAL_W-1:0] data_q;

	lfu_cell_ctl_t    ctl;
	logic [DEPTH-1:0] sel;
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] swap_vec;
	logic [DEPTH-1:0] first_oh;
	logic [VAL_W-1:0] hit_value;
	logic [CAP_W-1:0] eff_cap;
	logic             found;
	logic             evict;
	logic             finish;
	lfu_entry_t       new_entry;
	lfu_entry_t       cell_entry [DEPTH];

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign hit  = hit_q;
	assign data = data_q;

	// capacity zero acts as one, anything above DEPTH acts as DEPTH
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (cap_q > CAP_W'(DEPTH)) begin
			eff_cap = CAP_W'(DEPTH);
		end else begin
			eff_cap = cap_q;
		end
	end

	assign found    = |match_vec;
	assign first_oh = match_vec & (~match_vec + DEPTH'(1));
	assign evict    = (FILL_W'(eff_cap) <= fill_q) && (fill_q != '0);

	assign new_entry.key   = key_q;
	assign new_entry.value = value_q;
	assign new_entry.count = COUNT_W'(1);

	// value of the first matching cell
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_value = hit_value | ({VAL_W{first_oh[i]}} & cell_entry[i].value);
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		finish    = 1'b0;
		sel       = '0;
		ctl.op    = CELL_IDLE;
		ctl.put   = cmd_q;
		ctl.key   = key_q;
		ctl.value = value_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				ctl.op  = CELL_LOOK;
				state_d = ST_OP;
			end
			ST_OP: begin
				if (found) begin
					// bump the hit entry, then let it climb
					ctl.op  = CELL_HIT;
					sel     = first_oh;
					state_d = ST_PROMO;
				end else if (cmd_q == CMD_PUT) begin
					// evict-then-insert only replaces rank 0; plain insert shifts all up
					ctl.op  = CELL_SHIFT;
					sel     = evict ? DEPTH'(1) : '1;
					state_d = ST_PROMO;
				end else begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PROMO: begin
				ctl.op = CELL_PROMO;
				sel    = token_q;
				if (!(|swap_vec)) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == ST_OP) begin
			hit_q   <= found;
			data_q  <= (found && (cmd_q == CMD_GET)) ? hit_value : '0;
			token_q <= found ? first_oh : DEPTH'(1);
		end else if (state_q == ST_PROMO && (|swap_vec)) begin
			token_q <= token_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == ST_OP && !found && cmd_q == CMD_PUT && !evict) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// ---- cell row ----
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lfu_entry_t prev_e;
		lfu_entry_t next_e;
		logic       prev_sw;
		logic       next_v;

		if (i == 0) begin : g_first
			assign prev_e  = new_entry;
			assign prev_sw = 1'b0;
		end else begin : g_mid
			assign prev_e  = cell_entry[i-1];
			assign prev_sw = swap_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
			assign next_v = 1'b0;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
			assign next_v = (FILL_W'(i + 1) < fill_q);
		end

		lfu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sel        (sel[i]),
			.valid      (FILL_W'(i) < fill_q),
			.next_valid (next_v),
			.prev_swap  (prev_sw),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.match      (match_vec[i]),
			.swap       (swap_vec[i])
		);
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the LFU cache
// Drives get/put items through the start/busy port, mirrors the ranked
// entry row in a local predictor and checks every hit/data result in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lfu_pkg::*;

	// Gets per hammered key: enough to lift it well above the pack.
	localparam int HAMMER_RUN = 30;
	localparam int RAND_ITEMS = 1650;
	localparam int TAIL_WAIT  = DEPTH + 8;

	// What the driver pulls off its queue: an access item, a capacity
	// write (taken once the block has gone quiet), or a plain hold-off.
	typedef enum logic [1:0] {
		STEP_ACCESS,
		STEP_CAPACITY,
		STEP_SETTLE
	} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [CAP_W-1:0] cap;
		int unsigned      gap;
	} access_step_t;

	typedef struct {
		logic             op;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [VAL_W-1:0] data;
	} lookup_result_t;

	// DUT ports
	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             cmd;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;
	logic             done;
	logic             hit;
	logic [VAL_W-1:0] data;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	// Predictor state: entries in rank order, slot 0 is the next victim.
	lfu_entry_t       rank_row [DEPTH];
	int unsigned      row_fill;
	logic [CAP_W-1:0] cap_reg;

	access_step_t     access_q[$];     // pending stimulus
	lookup_result_t   due_results[$];  // predicted results not yet seen

	bit               took_item;       // set at the edge that accepts an item
	int unsigned      gap_left;
	int unsigned      mismatches;
	int unsigned      accepted;
	int unsigned      hits_seen;
	int unsigned      cap_writes;

	lfu_cache uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.key       (key),
		.value     (value),
		.done      (done),
		.hit       (hit),
		.data      (data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------

	// Move the entry at p behind every entry whose count is <= its own.
	function automatic void climb_rank(int unsigned p);
		lfu_entry_t t;
		while (p + 1 < row_fill && rank_row[p + 1].count <= rank_row[p].count) begin
			t               = rank_row[p];
			rank_row[p]     = rank_row[p + 1];
			rank_row[p + 1] = t;
			p++;
		end
	endfunction

	// Apply one get/put to the mirrored row and return the result it yields.
	function automatic lookup_result_t apply_access(logic op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		lookup_result_t r;
		int unsigned    pos;
		int unsigned    lim;
		bit             found;
		r.op   = op;
		r.key  = k;
		r.data = '0;
		found  = 1'b0;
		pos    = 0;
		for (int unsigned i = 0; i < row_fill; i++) begin
			if (!found && rank_row[i].key == k) begin
				found = 1'b1;
				pos   = i;
			end
		end
		if (found) begin
			if (op == CMD_GET)
				r.data = rank_row[pos].value;
			else
				rank_row[pos].value = v;
			if (rank_row[pos].count != COUNT_MAX)
				rank_row[pos].count = rank_row[pos].count + 1'b1;
			climb_rank(pos);
		end else if (op == CMD_PUT) begin
			lim = (cap_reg == '0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
			// full (or over a lowered capacity): drop the first-ranked entry
			if (row_fill >= lim && row_fill > 0) begin
				for (int unsigned i = 0; i + 1 < row_fill; i++)
					rank_row[i] = rank_row[i + 1];
				row_fill--;
			end
			for (int unsigned i = row_fill; i > 0; i--)
				rank_row[i] = rank_row[i - 1];
			rank_row[0] = '{key: k, value: v, count: COUNT_W'(1)};
			row_fill++;
			climb_rank(0);
		end
		r.hit = found;
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	function automatic void queue_access(logic op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, int unsigned gap);
		access_step_t s;
		s.kind  = STEP_ACCESS;
		s.op    = op;
		s.key   = k;
		s.value = v;
		s.cap   = '0;
		s.gap   = gap;
		access_q.push_back(s);
	endfunction

	function automatic void queue_step(step_kind_t kind, logic [CAP_W-1:0] c);
		access_step_t s;
		s.kind  = kind;
		s.op    = CMD_GET;
		s.key   = '0;
		s.value = '0;
		s.cap   = c;
		s.gap   = 0;
		access_q.push_back(s);
	endfunction

	// One random phase: keys come from a small pool a bit larger than the
	// capacity, skewed toward the front so counts spread out and entries
	// climb, get evicted and come back.
	function automatic void queue_random_phase(int unsigned cap, int unsigned n);
		logic [KEY_W-1:0] pool[$];
		int unsigned      psize;
		int unsigned      idx;
		int unsigned      alt;
		logic             op;
		logic [KEY_W-1:0] k;
		psize = cap + 2 + $urandom_range(0, 3);
		repeat (psize) pool.push_back($urandom());
		repeat (n) begin
			idx = $urandom_range(0, psize - 1);
			alt = $urandom_range(0, psize - 1);
			if (alt < idx)
				idx = alt;
			op = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
			k  = ($urandom_range(0, 99) < 4) ? KEY_W'($urandom()) : pool[idx];
			queue_access(op, k, $urandom(), pick_gap());
			if ($urandom_range(0, 149) == 0)
				queue_step(STEP_SETTLE, '0);
		end
	endfunction

	// -----------------------------------------------------------------------
	// Clock, reset, time limit
	// -----------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hang guard, sized well past the slowest legal run (every item at the
	// full climb plus every long gap).
	initial begin
		#100ms;
		$display("FAILURE");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Driver: inputs move on the falling edge only, one NBA per signal per
	// edge so a held start is never dropped and re-raised in one step.
	// -----------------------------------------------------------------------
	always @(negedge clk) begin : drive
		access_step_t s;
		logic         nxt_start;
		logic         nxt_we;
		nxt_start = start;
		nxt_we    = 1'b0;
		if (took_item) begin
			took_item = 1'b0;
			nxt_start = 1'b0;
		end
		if (arst_n && !nxt_start) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (access_q.size() > 0) begin
				s = access_q[0];
				case (s.kind)
					STEP_ACCESS: begin
						void'(access_q.pop_front());
						cmd       <= s.op;
						key       <= s.key;
						value     <= s.value;
						nxt_start = 1'b1;
						gap_left  = s.gap;
					end
					STEP_SETTLE: begin
						// hold until every outstanding result is back
						if (due_results.size() == 0 && !busy)
							void'(access_q.pop_front());
					end
					STEP_CAPACITY: begin
						// capacity only changes with the block idle
						if (due_results.size() == 0 && !busy) begin
							void'(access_q.pop_front());
							cfg_wdata <= s.cap;
							nxt_we    = 1'b1;
						end
					end
					default: void'(access_q.pop_front());
				endcase
			end
		end
		start  <= nxt_start;
		cfg_we <= nxt_we;
	end

	// -----------------------------------------------------------------------
	// Monitor / predictor hook: everything sampled on the rising edge.
	// A result at this edge belongs to an older item, so it is checked
	// before the item accepted at the same edge is predicted.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : watch
		lookup_result_t want;
		if (arst_n) begin
			if (done) begin
				if (hit === 1'b1)
					hits_seen++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result with nothing due: hit %0b data %08h",
							hit, data);
				end else begin
					want = due_results.pop_front();
					if (hit !== want.hit || data !== want.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"ERROR: %s key %08h: hit exp %0b got %0b,",
								" data exp %08h got %08h"},
								(want.op == CMD_PUT) ? "put" : "get", want.key,
								want.hit, hit, want.data, data);
					end
				end
			end
			if (cfg_we) begin
				cap_reg = cfg_wdata;
				cap_writes++;
			end
			if (start && !busy) begin
				due_results.push_back(apply_access(cmd, key, value));
				took_item = 1'b1;
				accepted++;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin : main
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		int unsigned      caps[$];

		// known values on every input from time zero
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = CMD_GET;
		key       = '0;
		value     = '0;
		cfg_we    = 1'b0;
		cfg_wdata = CAP_RESET;
		took_item = 1'b0;
		gap_left  = 0;
		mismatches = 0;
		accepted   = 0;
		hits_seen  = 0;
		cap_writes = 0;
		row_fill   = 0;
		cap_reg    = CAP_RESET;
		for (int i = 0; i < DEPTH; i++)
			rank_row[i] = '0;

		// --- directed, reset capacity (full depth) ---
		queue_access(CMD_GET, '0, '1, pick_gap());            // miss on empty
		queue_access(CMD_PUT, '0, '0, pick_gap());            // all-zero key/value
		queue_access(CMD_PUT, '1, '1, pick_gap());            // all-ones key/value
		queue_access(CMD_GET, '1, '0, pick_gap());            // hit, data all ones
		queue_access(CMD_GET, '0, '1, pick_gap());            // hit, data zero
		queue_access(CMD_PUT, '0, 32'hA5A5_5A5A, pick_gap()); // put hit: data 0
		queue_access(CMD_GET, '0, '0, pick_gap());            // sees new value
		queue_access(CMD_GET, 32'h1234_5678, '0, pick_gap()); // plain miss
		// fill to depth with count-1 entries
		for (int i = 0; i < DEPTH - 2; i++)
			queue_access(CMD_PUT, KEY_W'(32'h100 + i), $urandom(), pick_gap());
		// full: new key evicts the first-ranked entry, which then misses
		queue_access(CMD_PUT, 32'hDEAD_BEEF, $urandom(), pick_gap());
		queue_access(CMD_GET, 32'h100, '0, pick_gap());

		// capacity lowered well below the fill level: a new key swaps out
		// one victim and the fill level stays put
		queue_step(STEP_CAPACITY, CAP_W'(1));
		queue_access(CMD_PUT, 32'hC0DE_0001, $urandom(), pick_gap());
		queue_access(CMD_GET, 32'hC0DE_0001, '0, pick_gap());

		// --- random phases, each at its own capacity ---
		caps = '{16, 4, 1, 2, 8, 15, 3, 16, 0};
		caps[caps.size() - 1] = $urandom_range(1, DEPTH);
		foreach (caps[i]) begin
			queue_step(STEP_CAPACITY, CAP_W'(caps[i]));
			queue_random_phase(caps[i], RAND_ITEMS / caps.size());
		end

		// --- heavy reuse: hammer key A, bring in key B and do the same,
		// then alternate so two high, close counts keep trading places.
		// The hammer runs go without gaps to keep it short. ---
		key_a = $urandom();
		key_b = key_a ^ 32'h8000_0001;
		queue_step(STEP_CAPACITY, CAP_W'(DEPTH));
		queue_access(CMD_PUT, key_a, $urandom(), 0);
		repeat (HAMMER_RUN) queue_access(CMD_GET, key_a, '0, 0);
		queue_access(CMD_PUT, key_b, $urandom(), 0);
		repeat (HAMMER_RUN) queue_access(CMD_GET, key_b, '0, 0);
		repeat (8) begin
			queue_access(CMD_GET, key_a, '0, pick_gap());
			queue_access(CMD_PUT, key_b, $urandom(), pick_gap());
		end

		// release reset away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all stimulus in, then all results back, then a quiet tail
		while (access_q.size() != 0 || start)
			@(negedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Run: %0d get/put items (%0d hits), %0d capacity writes from 1 to %0d.",
			accepted, hits_seen, cap_writes, DEPTH);
		$display("Included eviction past a lowered capacity and two busy keys trading ranks.");
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
